FILE: design/efr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

	// Payload length field width and the largest length that fits in it
	localparam int LenBits = 24;
	localparam logic [23:0] LenLimit = 24'((64'd1 << LenBits) - 64'd1);

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;

	// Configuration register indexes
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CfgStartByte  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgEscapeByte = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgMaxLength  = 2'd2;

	localparam logic [7:0]  StartReset  = 8'd16;
	localparam logic [7:0]  EscapeReset = 8'd17;
	localparam logic [23:0] MaxLenReset = 24'd4096;

	// Result kinds
	typedef enum logic [2:0] {
		KindByte  = 3'd0,
		KindGood  = 3'd1,
		KindPcrc  = 3'd2,
		KindHcrc  = 3'd3,
		KindLong  = 3'd4,
		KindAbort = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  escape_byte;
		logic [23:0] max_length;
	} cfg_t;

	// One classified symbol from the front end: a start marker or an unescaped byte
	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} token_t;

	// CRC16, polynomial 0x1021, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/escaped_frame_receiver_crc16_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------
// in      | in_valid / in_stall  | in_byte[7:0]
// out     | out_valid / out_stall| out_byte[7:0], kind[2:0]
// cfg     | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[23:0]
//
// One byte per cycle sustained while out_stall stays low; a result is presented once
// its byte has passed the combinational classifier into a two-entry queue and the
// sequencer into the output register.
// Escape bytes and idle bytes produce no result.
// Reset clears the escape flag, queue, frame state and loads register defaults.
// in_stall rises only while the queue is full; out_stall backs up the queue.

module escaped_frame_receiver_crc16_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    in_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         out_byte,
	output logic [2:0]                         kind,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [efr_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [23:0]                   cfg_data
);
	import efr_pkg::*;

	cfg_t   cfg_q;
	logic   tok_push;
	token_t tok;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	token_t q_head;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= StartReset;
			cfg_q.escape_byte <= EscapeReset;
			cfg_q.max_length  <= MaxLenReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgStartByte:  cfg_q.start_byte  <= cfg_data[7:0];
				CfgEscapeByte: cfg_q.escape_byte <= cfg_data[7:0];
				CfgMaxLength:  cfg_q.max_length  <= cfg_data;
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	efr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.tok_push (tok_push),
		.tok      (tok)
	);

	efr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tok_push),
		.push_tok (tok),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	efr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind)
	);

endmodule

`default_nettype wire

FILE: design/efr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire efr_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    in_byte,
	input  wire logic          q_full,
	output logic               tok_push,
	output efr_pkg::token_t    tok
);
	import efr_pkg::*;

	logic esc_pending_q;
	logic accept;
	logic is_start;
	logic is_esc;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign is_start = (in_byte == cfg.start_byte);
	assign is_esc   = (in_byte == cfg.escape_byte);

	// Classify: start wins over escape, escape bytes are swallowed
	assign tok_push   = accept && (is_start || !is_esc);
	assign tok.start  = is_start;
	assign tok.data   = esc_pending_q ? (in_byte ^ cfg.escape_byte) : in_byte;

	// Track a pending escape across requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
		end else if (accept) begin
			esc_pending_q <= !is_start && is_esc;
		end
	end

endmodule

`default_nettype wire

FILE: design/efr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire efr_pkg::token_t push_tok,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output efr_pkg::token_t      head
);
	import efr_pkg::*;

	token_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	// Store the pushed token
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/efr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module efr_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire efr_pkg::cfg_t   cfg,
	input  wire logic            q_empty,
	input  wire efr_pkg::token_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [7:0]           out_byte,
	output logic [2:0]           kind
);
	import efr_pkg::*;

	typedef enum logic [8:0] {
		PhIdle  = 9'b000000001,
		PhLen1  = 9'b000000010,
		PhLen2  = 9'b000000100,
		PhLen3  = 9'b000001000,
		PhHcrcH = 9'b000010000,
		PhHcrcL = 9'b000100000,
		PhData  = 9'b001000000,
		PhPcrcH = 9'b010000000,
		PhPcrcL = 9'b100000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] len_q, len_d;
	logic [23:0] rcvd_q, rcvd_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic        emit;
	logic [7:0]  emit_byte;
	kind_t       emit_kind;
	logic        out_free;
	logic [7:0]  ch;
	logic [23:0] len_new;
	logic [23:0] rcvd_new;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	kind_t       kind_q;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = !q_empty && out_free;
	assign ch       = q_head.data;
	assign len_new  = {len_q[15:0], ch};
	assign rcvd_new = rcvd_q + 24'd1;

	// Frame sequencer: one token per cycle while the queue holds one and the output register is free
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		rcvd_d    = rcvd_q;
		crc_d     = crc_q;
		crc_hi_d  = crc_hi_q;
		emit      = 1'b0;
		emit_byte = 8'h00;
		emit_kind = KindByte;
		if (q_head.start) begin
			if (phase_q != PhIdle) begin
				emit      = 1'b1;
				emit_kind = KindAbort;
			end
			phase_d = PhLen1;
		end else begin
			unique case (phase_q)
				PhLen1: begin
					rcvd_d   = 24'd0;
					crc_hi_d = 8'h00;
					crc_d    = crc16_byte(CrcInit, ch);
					len_d    = {16'h0000, ch};
					phase_d  = PhLen2;
				end
				PhLen2: begin
					crc_d   = crc16_byte(crc_q, ch);
					len_d   = len_new;
					phase_d = PhLen3;
				end
				PhLen3: begin
					crc_d = crc16_byte(crc_q, ch);
					len_d = len_new;
					if (len_new > cfg.max_length || len_new > LenLimit) begin
						phase_d   = PhIdle;
						emit      = 1'b1;
						emit_kind = KindLong;
					end else begin
						phase_d = PhHcrcH;
					end
				end
				PhHcrcH: begin
					crc_hi_d = ch;
					phase_d  = PhHcrcL;
				end
				PhHcrcL: begin
					crc_hi_d = ch;
					if (crc_q != {crc_hi_q, ch}) begin
						phase_d   = PhIdle;
						emit      = 1'b1;
						emit_kind = KindHcrc;
					end else if (len_q == 24'd0) begin
						phase_d = PhPcrcH;
					end else begin
						phase_d = PhData;
					end
				end
				PhData: begin
					crc_d     = crc16_byte((rcvd_q == 24'd0) ? CrcInit : crc_q, ch);
					rcvd_d    = rcvd_new;
					if (rcvd_new >= len_q) begin
						phase_d = PhPcrcH;
					end
					emit      = 1'b1;
					emit_byte = ch;
					emit_kind = KindByte;
				end
				PhPcrcH: begin
					crc_hi_d = ch;
					phase_d  = PhPcrcL;
				end
				PhPcrcL: begin
					crc_hi_d  = ch;
					phase_d   = PhIdle;
					emit      = 1'b1;
					emit_kind = (crc_q == {crc_hi_q, ch}) ? KindGood : KindPcrc;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Hold frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PhIdle;
			len_q    <= 24'd0;
			rcvd_q   <= 24'd0;
			crc_q    <= CrcInit;
			crc_hi_q <= 8'h00;
		end else if (q_pop) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			rcvd_q   <= rcvd_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	// Output register: load when free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= q_pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_byte_q <= emit_byte;
			kind_q     <= emit_kind;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign kind      = kind_q;

endmodule

`default_nettype wire

FILE: sim/tb_escaped_frame_receiver_crc16_core.sv
`timescale 1ns / 1ps

module tb_escaped_frame_receiver_crc16_core;
	import efr_pkg::*;

	localparam int CycleLimit   = 400_000;
	localparam int SettleCycles = 8;

	// Receiver phases as tracked by the predictor
	typedef enum logic [3:0] {
		PhIdle, PhLen1, PhLen2, PhLen3, PhHcrcH, PhHcrcL, PhData, PhPcrcH, PhPcrcL
	} rx_phase_t;

	typedef enum int {
		FaultNone, FaultHeader, FaultPayload, FaultLength, FaultTruncate
	} frame_fault_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      code;
	} rx_result_t;

	// Deframer predictor plus the store of results still to arrive
	class deframe_scoreboard;
		logic [7:0]  start_val;
		logic [7:0]  escape_val;
		logic [23:0] max_val;
		rx_phase_t   st_phase;
		logic        esc_armed;
		logic [23:0] len_field;
		logic [23:0] pay_count;
		logic [15:0] crc_acc;
		logic [15:0] crc_got;
		rx_result_t  pending_results[$];
		int          errors;

		function new();
			start_val  = StartReset;
			escape_val = EscapeReset;
			max_val    = MaxLenReset;
			st_phase   = PhIdle;
			esc_armed  = 1'b0;
			len_field  = '0;
			pay_count  = '0;
			crc_acc    = CrcInit;
			crc_got    = '0;
			errors     = 0;
		endfunction

		// Shift one byte through the CRC, MSB first
		static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
			logic [15:0] c;
			logic        fb;
			c = crc;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c  = {c[14:0], 1'b0};
				if (fb)
					c = c ^ CrcPoly;
			end
			return c;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [23:0] value);
			case (idx)
				CfgStartByte:  start_val  = value[7:0];
				CfgEscapeByte: escape_val = value[7:0];
				CfgMaxLength:  max_val    = value;
				default: ;
			endcase
		endfunction

		function void push_result(logic [7:0] data, kind_t code);
			rx_result_t r;
			r.data = data;
			r.code = code;
			pending_results.push_back(r);
		endfunction

		// Advance the predicted receiver by one accepted raw byte
		function void note_byte(logic [7:0] raw);
			logic [7:0] ch;
			ch = raw;
			// start wins over escape, and restarts from any phase
			if (ch == start_val) begin
				if (st_phase != PhIdle)
					push_result(8'h00, KindAbort);
				esc_armed = 1'b0;
				st_phase  = PhLen1;
				return;
			end
			if (ch == escape_val) begin
				esc_armed = 1'b1;
				return;
			end
			if (esc_armed) begin
				ch        = ch ^ escape_val;
				esc_armed = 1'b0;
			end
			case (st_phase)
				PhLen1: begin
					crc_got   = '0;
					pay_count = '0;
					crc_acc   = crc_step(CrcInit, ch);
					len_field = {16'h0000, ch};
					st_phase  = PhLen2;
				end
				PhLen2: begin
					crc_acc   = crc_step(crc_acc, ch);
					len_field = {len_field[15:0], ch};
					st_phase  = PhLen3;
				end
				PhLen3: begin
					crc_acc   = crc_step(crc_acc, ch);
					len_field = {len_field[15:0], ch};
					// a 24-bit length always fits the length field
					if (len_field > max_val) begin
						st_phase = PhIdle;
						push_result(8'h00, KindLong);
					end else begin
						st_phase = PhHcrcH;
					end
				end
				PhHcrcH: begin
					crc_got  = {8'h00, ch};
					st_phase = PhHcrcL;
				end
				PhHcrcL: begin
					crc_got = {crc_got[7:0], ch};
					if (crc_acc != crc_got) begin
						st_phase = PhIdle;
						push_result(8'h00, KindHcrc);
					end else begin
						st_phase = (len_field == '0) ? PhPcrcH : PhData;
					end
				end
				PhData: begin
					crc_acc   = crc_step((pay_count == '0) ? CrcInit : crc_acc, ch);
					pay_count = pay_count + 24'd1;
					if (pay_count >= len_field)
						st_phase = PhPcrcH;
					push_result(ch, KindByte);
				end
				PhPcrcH: begin
					crc_got  = {8'h00, ch};
					st_phase = PhPcrcL;
				end
				PhPcrcL: begin
					crc_got  = {crc_got[7:0], ch};
					st_phase = PhIdle;
					push_result(8'h00, (crc_acc == crc_got) ? KindGood : KindPcrc);
				end
				default: ;
			endcase
		endfunction

		// Compare one delivered result with the oldest one predicted
		function void check_result(logic [7:0] got_byte, logic [2:0] got_kind);
			rx_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual byte %h kind %0d",
					$time, got_byte, got_kind);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got_kind !== want.code) begin
				$display("%0t: kind mismatch, expected %0d actual %0d",
					$time, want.code, got_kind);
				errors++;
			end
			if (got_byte !== want.data) begin
				$display("%0t: byte mismatch, expected %h actual %h",
					$time, want.data, got_byte);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          in_byte;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [7:0]          out_byte;
	logic [2:0]          kind;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [23:0]         cfg_data;

	deframe_scoreboard sb;
	logic [7:0] tx_bytes[$];
	logic [7:0] payload_src[$];
	int         burst_left = 0;
	int         stall_run = 0;
	int         stall_pick;
	int         cycle_count = 0;

	escaped_frame_receiver_crc16_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hold off the result side: mostly short stalls, a few long, some quiet runs
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 55) begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(0, 20);
			end else if (stall_pick < 62) begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(60, 150);
			end else if (stall_pick < 95) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(10, 40);
			end
		end
	end

	// Check every request taken from the result side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, kind);
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one raw byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				burst_left = $urandom_range(20, 60);
				gap = 0;
			end else if (pick < 55) begin
				gap = 0;
			end else if (pick < 92) begin
				gap = $urandom_range(1, 3);
			end else begin
				gap = $urandom_range(6, 40);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
	endtask

	task automatic send_queue();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// Wait until every predicted result is in and the pipeline has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
	endtask

	task automatic apply_setting(input logic [7:0] s, input logic [7:0] e,
		input logic [23:0] m);
		drain();
		write_reg(CfgStartByte, {16'h0000, s});
		write_reg(CfgEscapeByte, {16'h0000, e});
		write_reg(CfgMaxLength, m);
		cfg_valid <= 1'b0;
	endtask

	// Stuff a frame byte if it collides with a marker
	function void put_coded(logic [7:0] b);
		if (b == sb.start_val || b == sb.escape_val) begin
			tx_bytes.push_back(sb.escape_val);
			tx_bytes.push_back(b ^ sb.escape_val);
		end else begin
			tx_bytes.push_back(b);
		end
	endfunction

	// Queue one frame, optionally corrupted or cut short after cut payload bytes
	task automatic build_frame(input int len, input frame_fault_t fault, input int cut);
		logic [23:0] len_bits;
		logic [15:0] hdr_crc;
		logic [15:0] pay_crc;
		logic [15:0] flip;
		logic [7:0]  pay;
		len_bits = len[23:0];
		flip     = 16'($urandom_range(1, 65535));
		tx_bytes.push_back(sb.start_val);
		hdr_crc = CrcInit;
		for (int k = 2; k >= 0; k--) begin
			put_coded(len_bits[k*8 +: 8]);
			hdr_crc = deframe_scoreboard::crc_step(hdr_crc, len_bits[k*8 +: 8]);
		end
		if (fault == FaultLength)
			return;
		// an empty payload repeats the header CRC in the trailer
		pay_crc = hdr_crc;
		if (fault == FaultHeader)
			hdr_crc = hdr_crc ^ flip;
		put_coded(hdr_crc[15:8]);
		put_coded(hdr_crc[7:0]);
		for (int i = 0; i < len; i++) begin
			if (fault == FaultTruncate && i == cut)
				return;
			pay = (payload_src.size() != 0) ? payload_src.pop_front()
				: 8'($urandom_range(0, 255));
			pay_crc = deframe_scoreboard::crc_step((i == 0) ? CrcInit : pay_crc, pay);
			put_coded(pay);
		end
		if (fault == FaultTruncate)
			return;
		if (fault == FaultPayload)
			pay_crc = pay_crc ^ flip;
		put_coded(pay_crc[15:8]);
		put_coded(pay_crc[7:0]);
	endtask

	// Mostly well-formed frames with random content, plus noise and broken frames
	task automatic run_random(input int budget);
		int          sent;
		int          pick;
		int          len;
		logic [31:0] over;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
			if (len > sb.max_val)
				len = int'(sb.max_val);
			if (pick < 8) begin
				repeat ($urandom_range(1, 4))
					tx_bytes.push_back(($urandom_range(0, 3) == 0) ? sb.escape_val
						: 8'($urandom_range(0, 255)));
				send_queue();
			end else begin
				if (pick < 68) begin
					build_frame(len, FaultNone, 0);
				end else if (pick < 76) begin
					build_frame(len, FaultHeader, 0);
				end else if (pick < 84) begin
					build_frame(len, FaultPayload, 0);
				end else if (pick < 90 && sb.max_val != 24'hFFFFFF) begin
					over = 32'(sb.max_val) + 32'd1;
					if ($urandom_range(0, 1) == 0) begin
						len = over + $urandom_range(0, 3);
						if (len > 32'hFFFFFF)
							len = 32'hFFFFFF;
					end else begin
						len = $urandom_range(over, 32'hFFFFFF);
					end
					build_frame(len, FaultLength, 0);
				end else begin
					build_frame(len, FaultTruncate, $urandom_range(0, len));
				end
				sent += tx_bytes.size();
				send_queue();
				if ($urandom_range(0, 49) == 0)
					drain();
			end
		end
	endtask

	initial begin
		sb = new();
		in_valid  <= 1'b0;
		in_byte   <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= CfgStartByte;
		cfg_data  <= 24'h000000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle bytes are dropped; an idle escape is cleared by the next byte or a start
		tx_bytes = {8'h00, 8'hFF, sb.escape_val, 8'h22, sb.escape_val};
		send_queue();
		build_frame(0, FaultNone, 0);
		payload_src = {sb.start_val, sb.escape_val, 8'h00, 8'hFF};
		build_frame(4, FaultNone, 0);
		build_frame(0, FaultHeader, 0);
		build_frame(32'(sb.max_val) + 1, FaultLength, 0);
		build_frame(3, FaultTruncate, 1);
		send_queue();

		run_random(180);
		apply_setting(8'h7E, 8'h7D, 24'hFFFFFF);
		// largest length passes the check, then a new start aborts it
		build_frame(32'hFFFFFF, FaultTruncate, 3);
		send_queue();
		run_random(180);
		apply_setting(8'h00, 8'hFF, 24'd0);
		run_random(150);
		apply_setting(8'hFF, 8'h00, 24'd300);
		run_random(120);
		// start and escape share a value: the byte is a start
		apply_setting(8'h55, 8'h55, 24'd20);
		run_random(150);
		apply_setting(StartReset, EscapeReset, MaxLenReset);
		run_random(180);

		drain();
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: escaped_frame_receiver_crc16_core.f
design/efr_pkg.sv
design/efr_front.sv
design/efr_queue.sv
design/efr_back.sv
design/escaped_frame_receiver_crc16_core.sv
sim/tb_escaped_frame_receiver_crc16_core.sv
